[hdl/tccw_pkg.sv]
// Shared types and constants of the text console character writer.
package tccw_pkg;

	// Default attribute for clears and the character used for blank cells.
	localparam logic [7:0] DEFAULT_ATTR = 8'h07;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Command codes carried in tuser.
	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_CLEAR_DEF = 2'd1;
	localparam logic [1:0] CMD_CLEAR_CFG = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	// Control characters.
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN = 8'd13;

	// Operation that the back carries out for one queued item.
	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_RETURN,
		OP_BACKSPACE,
		OP_TAB,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  ch;
		logic        use_cfg;
		logic        in_range;
		logic [10:0] cell_addr;
	} item_t;

	// One result, last field in the lowest bits.
	typedef struct packed {
		logic [7:0]  cell_attr;
		logic [7:0]  cell_char;
		logic [10:0] cursor_pos;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
	} result_t;

endpackage

[hdl/tccw_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/tccw_front.sv]
// Front of the console writer: accepts transactions, classifies them and queues them.
module tccw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hold,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // ch [7:0], cell_addr [18:8], zero [23:19]
	input  logic [1:0]            s_tuser,   // cmd [1:0]
	output logic                  q_valid,
	output tccw_pkg::item_t       q_item,
	input  logic                  q_pop
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int QD = tccw_pkg::QUEUE_DEPTH;
	localparam int QA = $clog2(QD);
	localparam int CNT_W = QA + 1;

	tccw_pkg::item_t item;
	tccw_pkg::item_t queue_q [QD];
	logic [QA-1:0]   wr_ptr_q;
	logic [QA-1:0]   rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic            push;
	logic            pop;

	always_comb begin
		item.ch = s_tdata[7:0];
		item.cell_addr = s_tdata[18:8];
		item.use_cfg = 1'b0;
		item.in_range = 32'(s_tdata[18:8]) < 32'(CELLS);
		item.op = tccw_pkg::OP_CHAR;
		case (s_tuser)
			tccw_pkg::CMD_PUT: begin
				case (s_tdata[7:0])
					tccw_pkg::CH_BACKSPACE: item.op = tccw_pkg::OP_BACKSPACE;
					tccw_pkg::CH_TAB:       item.op = tccw_pkg::OP_TAB;
					tccw_pkg::CH_NEWLINE:   item.op = tccw_pkg::OP_NEWLINE;
					tccw_pkg::CH_RETURN:    item.op = tccw_pkg::OP_RETURN;
					default:                item.op = tccw_pkg::OP_CHAR;
				endcase
			end
			tccw_pkg::CMD_CLEAR_DEF: item.op = tccw_pkg::OP_CLEAR;
			tccw_pkg::CMD_CLEAR_CFG: begin
				item.op = tccw_pkg::OP_CLEAR;
				item.use_cfg = 1'b1;
			end
			tccw_pkg::CMD_READ: item.op = tccw_pkg::OP_READ;
			default: item.op = tccw_pkg::OP_CHAR;
		endcase
	end

	assign s_tready = !hold && (count_q != CNT_W'(QD));
	assign push = s_tvalid && s_tready;
	assign q_valid = count_q != '0;
	assign pop = q_pop && q_valid;
	assign q_item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/tccw_back.sv]
// Back of the console writer: cursor state, screen store sequencer and result register.
module tccw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      text_attr,
	input  logic            q_valid,
	input  tccw_pkg::item_t q_item,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [39:0]     m_tdata,
	output logic            busy_init
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int PTR_W = ADDR_W + 1;
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int TP_W = $clog2(TAB_STOP);

	localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
	localparam logic [ADDR_W-1:0] COL_STEP = ADDR_W'(COLUMNS);
	localparam logic [PTR_W-1:0]  PTR_FIRST_SRC = PTR_W'(COLUMNS);
	localparam logic [PTR_W-1:0]  PTR_END = PTR_W'(CELLS);
	localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(CELLS - 1);
	localparam logic [PTR_W-1:0]  PTR_BOTTOM = PTR_W'((ROWS - 1) * COLUMNS);
	localparam logic [TP_W-1:0]   LAST_PHASE = TP_W'(TAB_STOP - 1);
	localparam logic [TP_W-1:0]   LAST_COL_PHASE = TP_W'((COLUMNS - 1) % TAB_STOP);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_TAB,
		ST_SCROLL,
		ST_RDATA,
		ST_RESULT
	} state_t;

	state_t              state_q;
	logic                init_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [ADDR_W-1:0]   base_q;
	logic [TP_W-1:0]     phase_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [7:0]          fill_attr_q;
	logic                rd_pend_s1;
	logic [ADDR_W-1:0]   wr_addr_s1;
	logic [15:0]         rd_q;
	logic                m_valid_q;
	tccw_pkg::result_t   result_q;

	logic [ADDR_W-1:0]   cur_addr;
	logic [ADDR_W+10:0]  pos_ext;
	logic [COL_W+6:0]    col_ext;
	logic [ROW_W+4:0]    row_ext;
	logic [ADDR_W+10:0]  rd_addr_ext;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [15:0]         wdata;
	logic                re;
	logic [ADDR_W-1:0]   raddr;
	logic [15:0]         rdata;
	logic [TP_W-1:0]     phase_inc;
	logic [TP_W-1:0]     phase_dec;

	assign cur_addr = base_q + {{(ADDR_W - COL_W){1'b0}}, col_q};
	assign pos_ext = {11'b0, cur_addr};
	assign col_ext = {7'b0, col_q};
	assign row_ext = {5'b0, row_q};
	assign rd_addr_ext = {{ADDR_W{1'b0}}, q_item.cell_addr};
	assign phase_inc = (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;
	assign phase_dec = (phase_q == '0) ? LAST_PHASE : phase_q - 1'b1;

	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign busy_init = init_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata = {1'b0, result_q};

	// Screen store port control.
	always_comb begin
		we = 1'b0;
		waddr = cur_addr;
		wdata = {text_attr, tccw_pkg::BLANK_CHAR};
		re = 1'b0;
		raddr = rd_addr_ext[ADDR_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.op)
						tccw_pkg::OP_CHAR: begin
							we = 1'b1;
							wdata = {text_attr, q_item.ch};
						end
						tccw_pkg::OP_BACKSPACE: begin
							we = (col_q != '0) || (row_q != '0);
							waddr = cur_addr - 1'b1;
						end
						tccw_pkg::OP_READ: re = q_item.in_range;
						default: we = 1'b0;
					endcase
				end
			end
			ST_TAB: we = 1'b1;
			ST_SCROLL: begin
				re = ptr_q < PTR_END;
				raddr = ptr_q[ADDR_W-1:0];
				we = rd_pend_s1;
				waddr = wr_addr_s1;
				wdata = rdata;
			end
			ST_FILL: begin
				we = 1'b1;
				waddr = ptr_q[ADDR_W-1:0];
				wdata = {fill_attr_q, tccw_pkg::BLANK_CHAR};
			end
			default: we = 1'b0;
		endcase
	end

	tccw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			init_q <= 1'b1;
			col_q <= '0;
			row_q <= '0;
			base_q <= '0;
			phase_q <= '0;
			ptr_q <= '0;
			fill_attr_q <= tccw_pkg::DEFAULT_ATTR;
			rd_pend_s1 <= 1'b0;
			wr_addr_s1 <= '0;
			rd_q <= '0;
			m_valid_q <= 1'b0;
			result_q <= '0;
		end else begin
			if ((state_q == ST_RESULT) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rd_q <= '0;
						case (q_item.op)
							tccw_pkg::OP_CHAR, tccw_pkg::OP_NEWLINE: begin
								if ((q_item.op == tccw_pkg::OP_CHAR) && (col_q != LAST_COL)) begin
									col_q <= col_q + 1'b1;
									phase_q <= phase_inc;
									state_q <= ST_RESULT;
								end else begin
									col_q <= '0;
									phase_q <= '0;
									if (row_q == LAST_ROW) begin
										ptr_q <= PTR_FIRST_SRC;
										rd_pend_s1 <= 1'b0;
										state_q <= ST_SCROLL;
									end else begin
										row_q <= row_q + 1'b1;
										base_q <= base_q + COL_STEP;
										state_q <= ST_RESULT;
									end
								end
							end
							tccw_pkg::OP_RETURN: begin
								col_q <= '0;
								phase_q <= '0;
								state_q <= ST_RESULT;
							end
							tccw_pkg::OP_BACKSPACE: begin
								if (col_q != '0) begin
									col_q <= col_q - 1'b1;
									phase_q <= phase_dec;
								end else if (row_q != '0) begin
									row_q <= row_q - 1'b1;
									base_q <= base_q - COL_STEP;
									col_q <= LAST_COL;
									phase_q <= LAST_COL_PHASE;
								end
								state_q <= ST_RESULT;
							end
							tccw_pkg::OP_TAB: state_q <= ST_TAB;
							tccw_pkg::OP_CLEAR: begin
								col_q <= '0;
								row_q <= '0;
								base_q <= '0;
								phase_q <= '0;
								ptr_q <= '0;
								fill_attr_q <= q_item.use_cfg ? text_attr : tccw_pkg::DEFAULT_ATTR;
								state_q <= ST_FILL;
							end
							tccw_pkg::OP_READ: begin
								state_q <= q_item.in_range ? ST_RDATA : ST_RESULT;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_TAB: begin
					// One blank cell per cycle until the next tab stop or the end of the row.
					if (col_q == LAST_COL) begin
						col_q <= '0;
						phase_q <= '0;
						if (row_q == LAST_ROW) begin
							ptr_q <= PTR_FIRST_SRC;
							rd_pend_s1 <= 1'b0;
							state_q <= ST_SCROLL;
						end else begin
							row_q <= row_q + 1'b1;
							base_q <= base_q + COL_STEP;
							state_q <= ST_RESULT;
						end
					end else begin
						col_q <= col_q + 1'b1;
						phase_q <= phase_inc;
						if (phase_q == LAST_PHASE) begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_SCROLL: begin
					// Read a cell one row down and write it back one row up in the next cycle.
					if (ptr_q < PTR_END) begin
						ptr_q <= ptr_q + 1'b1;
						rd_pend_s1 <= 1'b1;
						wr_addr_s1 <= ptr_q[ADDR_W-1:0] - COL_STEP;
					end else begin
						rd_pend_s1 <= 1'b0;
						ptr_q <= PTR_BOTTOM;
						fill_attr_q <= text_attr;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (ptr_q == PTR_LAST) begin
						init_q <= 1'b0;
						state_q <= init_q ? ST_IDLE : ST_RESULT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_RDATA: begin
					rd_q <= rdata;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!m_valid_q || m_tready) begin
						result_q.cursor_col <= col_ext[6:0];
						result_q.cursor_row <= row_ext[4:0];
						result_q.cursor_pos <= pos_ext[10:0];
						result_q.cell_char <= rd_q[7:0];
						result_q.cell_attr <= rd_q[15:8];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/text_console_char_writer.sv]
// Top level of the text console character writer: stream ports, register port and the two halves.
//
// The console keeps a screen of ROWS x COLUMNS cells, each a character byte and an attribute
// byte, and a cursor. Each input transaction carries a command in tuser: put a character
// (newline, carriage return, backspace and tab are interpreted, everything else is written with
// the text_attr register and advances the cursor), clear the screen with attribute 0x07, clear it
// with text_attr, or read one cell. Exactly one output transaction follows every input
// transaction, in order, giving the cursor column, row and linear position after the command
// and, for a read, the cell's character and attribute (zero otherwise). A front stage accepts
// and classifies transactions into a four-entry queue; the back stage executes them one at a
// time against a single-port-write, single-port-read screen RAM and holds the result in an
// output register, so the input keeps flowing while a result waits to be taken, until the queue
// is full. A tab writes blanks up to the next tab stop or the end of the row, a clear writes
// every cell once (one RAM write per cell), and a line feed or wrap that scrolls moves every row
// but the top up by one and then blanks the bottom row, all bounded by the one write port of the
// screen RAM. After reset the block runs a clearing pass over all ROWS*COLUMNS cells (2000 with
// the defaults) during which s_tready stays low; register writes are taken at any time but
// should be made while idle.
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25,
	parameter int TAB_STOP = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // ch [7:0], cell_addr [18:8], zero [23:19]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cursor_col [6:0], cursor_row [11:7], cursor_pos [22:12],
	                               // cell_char [30:23], cell_attr [38:31], zero [39]
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Word index of the text attribute register.
	localparam logic REG_TEXT_ATTR = 1'b0;

	logic            attr_sel;
	logic [7:0]      attr_q;
	logic            cfg_write;
	logic            busy_init;
	logic            q_valid;
	logic            q_pop;
	tccw_pkg::item_t q_item;

	// The only register: attribute of written cells and of blanks but the 0x07 clears.
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign attr_sel = paddr[2] == REG_TEXT_ATTR;
	assign prdata = attr_sel ? {24'b0, attr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tccw_pkg::DEFAULT_ATTR;
		end else if (cfg_write && attr_sel) begin
			attr_q <= pwdata[7:0];
		end
	end

	// Except in the reset clear, the front queues while the back is busy, until it is full.
	tccw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.hold    (busy_init),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// The back owns the cursor, the screen RAM and the output register.
	tccw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB_STOP)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_attr(attr_q),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.busy_init(busy_init)
	);

endmodule
